/* src/spimp_pkg.sv */
// shared types and constants for the spi master port
package spimp_pkg;

  // bus access codes carried with each tick
  typedef enum logic [1:0] {
    ACT_NONE        = 2'd0,
    ACT_WRITE       = 2'd1,
    ACT_READ_DATA   = 2'd2,
    ACT_READ_STATUS = 2'd3
  } action_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_ENABLE    = 2'd0,
    CFG_PRESCALER = 2'd1,
    CFG_CPOL      = 2'd2,
    CFG_CPHA      = 2'd3
  } cfg_idx_t;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 3;
  localparam int PRESC_W     = 3;
  localparam int DIV_W       = 7;
  localparam int BITCNT_W    = 4;
  localparam int BYTE_W      = 8;
  localparam int LIMIT_W     = 8;

  // status register bit positions
  localparam int STAT_RXNE_BIT = 0;
  localparam int STAT_TXE_BIT  = 1;
  localparam int STAT_BSY_BIT  = 7;

  localparam logic [BITCNT_W-1:0] BITS_PER_BYTE = 4'd8;

  // one tick of the peripheral bus
  typedef struct packed {
    logic [1:0]        action;
    logic [BYTE_W-1:0] write_data;
    logic              miso_in;
  } in_t;

  // line levels and status after one tick
  typedef struct packed {
    logic              sclk_out;
    logic              mosi_out;
    logic [BYTE_W-1:0] read_data;
    logic              tx_empty;
    logic              rx_not_empty;
    logic              busy_res;
  } out_t;

  // configuration seen by the shift engine
  typedef struct packed {
    logic               enable;
    logic [PRESC_W-1:0] prescaler_code;
    logic               clock_polarity;
    logic               clock_phase;
  } cfg_t;

endpackage

/* src/spi_master_port_unit.sv */
// top level of the spi master port: config registers, engine, output skid buffer
//
//  channel | direction | handshake      | payload
//  in_     | input     | valid / stall  | in_t  (action, write_data, miso_in)
//  out_    | output    | valid / stall  | out_t (sclk, mosi, read data, status)
//  cfg_    | input     | valid / ready  | index + data, four registers
//
// One transaction per cycle while in_stall is low; each result is registered.
// The shift engine step is a single combinational pass between the state and
// output registers; a two-entry output buffer lets one more tick in while a
// result is stalled, so in_stall rises only when both entries are full.
// Synchronous active-low reset clears all control state and the config registers.
module spi_master_port_unit
  import spimp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_t                    in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_t                   out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  out_t result;
  out_t out_data_r, out_data_nxt;
  out_t skid_data_r, skid_data_nxt;
  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  logic in_fire, out_fire;

  assign cfg_ready = 1'b1;

  // config register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ENABLE:    cfg_nxt.enable         = cfg_data[0];
        CFG_PRESCALER: cfg_nxt.prescaler_code = cfg_data[PRESC_W-1:0];
        CFG_CPOL:      cfg_nxt.clock_polarity = cfg_data[0];
        CFG_CPHA:      cfg_nxt.clock_phase    = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // handshakes
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;
  assign in_stall = skid_valid_r;

  spimp_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_i   (in_fire),
    .cfg_i    (cfg_r),
    .item_i   (in_data),
    .result_o (result)
  );

  // output register with skid entry
  always_comb begin
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r;
    skid_data_nxt  = skid_data_r;
    skid_valid_nxt = skid_valid_r;
    if (out_fire || !out_valid_r) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_data_nxt  = result;
        out_valid_nxt = in_fire;
      end
    end else if (in_fire) begin
      skid_data_nxt  = result;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // skid entry is only used behind a held output entry
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid without output entry");

  // skid entry fills only when the output entry was stalled
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid entry filled without a stalled output");

  // idle bus keeps sck at its idle level
  a_idle_sck: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !result.busy_res) |-> (result.sclk_out == cfg_r.clock_polarity))
    else $error("sck not at idle level while idle");

  // an enabled idle engine never leaves a byte in the transmit buffer
  a_no_stuck_tx: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && cfg_r.enable) |-> (result.busy_res || result.tx_empty))
    else $error("buffered byte not started while idle");

endmodule

/* src/spimp_core.sv */
// spi shift engine: buffers, clock divider and one step per bus tick
module spimp_core
  import spimp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic step_i,
  input  cfg_t cfg_i,
  input  in_t  item_i,
  output out_t result_o
);

  logic [BYTE_W-1:0]   tx_buffer_r, tx_buffer_nxt;
  logic                tx_full_r, tx_full_nxt;
  logic [BYTE_W-1:0]   shift_reg_r, shift_reg_nxt;
  logic [BITCNT_W-1:0] bit_count_r, bit_count_nxt;
  logic [DIV_W-1:0]    div_count_r, div_count_nxt;
  logic [BYTE_W-1:0]   rx_buffer_r, rx_buffer_nxt;
  logic                rx_full_r, rx_full_nxt;
  logic                shifting_r, shifting_nxt;
  logic                phase_r, phase_nxt;
  logic                mosi_r, mosi_nxt;
  logic                latch_r, latch_nxt;
  logic [BYTE_W-1:0]   rdata;

  // bus access, one engine step, then the start check
  always_comb begin
    logic [DIV_W-1:0]    div_inc;
    logic [LIMIT_W-1:0]  limit;
    logic [BITCNT_W-1:0] cnt_inc;
    logic                sck_edge;

    tx_buffer_nxt = tx_buffer_r;
    tx_full_nxt   = tx_full_r;
    shift_reg_nxt = shift_reg_r;
    bit_count_nxt = bit_count_r;
    div_count_nxt = div_count_r;
    rx_buffer_nxt = rx_buffer_r;
    rx_full_nxt   = rx_full_r;
    shifting_nxt  = shifting_r;
    phase_nxt     = phase_r;
    mosi_nxt      = mosi_r;
    latch_nxt     = latch_r;
    rdata         = '0;

    // bus access uses the state before this tick
    case (item_i.action)
      ACT_WRITE: begin
        if (!tx_full_r) begin
          tx_buffer_nxt = item_i.write_data;
          tx_full_nxt   = 1'b1;
        end
      end
      ACT_READ_DATA: begin
        rdata       = rx_buffer_r;
        rx_full_nxt = 1'b0;
      end
      ACT_READ_STATUS: begin
        rdata[STAT_RXNE_BIT] = rx_full_r;
        rdata[STAT_TXE_BIT]  = ~tx_full_r;
        rdata[STAT_BSY_BIT]  = shifting_r;
      end
      default: ;
    endcase

    // clock divider: an sck edge when the count reaches the limit or wraps
    div_inc  = div_count_r + DIV_W'(1);
    limit    = LIMIT_W'(1) << cfg_i.prescaler_code;
    sck_edge = ({1'b0, div_inc} >= limit) || (div_inc == '0);
    cnt_inc  = bit_count_r + BITCNT_W'(1);

    if (shifting_r) begin
      div_count_nxt = div_inc;
      if (sck_edge) begin
        div_count_nxt = '0;
        phase_nxt     = ~phase_r;
        if (!phase_r) begin
          // leading edge
          if (cfg_i.clock_phase) begin
            mosi_nxt      = shift_reg_r[BYTE_W-1];
            shift_reg_nxt = {shift_reg_r[BYTE_W-2:0], 1'b0};
          end else begin
            latch_nxt = item_i.miso_in;
          end
        end else begin
          // trailing edge
          if (cfg_i.clock_phase) begin
            shift_reg_nxt = {shift_reg_r[BYTE_W-1:1], shift_reg_r[0] | item_i.miso_in};
          end else begin
            shift_reg_nxt = {shift_reg_r[BYTE_W-2:0], latch_r};
          end
          bit_count_nxt = cnt_inc;
          if (cnt_inc >= BITS_PER_BYTE) begin
            shifting_nxt  = 1'b0;
            bit_count_nxt = '0;
            if (!rx_full_nxt) begin
              rx_buffer_nxt = shift_reg_nxt;
              rx_full_nxt   = 1'b1;
            end
          end else if (!cfg_i.clock_phase) begin
            mosi_nxt = shift_reg_nxt[BYTE_W-1];
          end
        end
      end
    end

    // start a buffered byte when idle and enabled
    if (!shifting_nxt && tx_full_nxt && cfg_i.enable) begin
      shift_reg_nxt = tx_buffer_nxt;
      tx_full_nxt   = 1'b0;
      shifting_nxt  = 1'b1;
      bit_count_nxt = '0;
      div_count_nxt = '0;
      phase_nxt     = 1'b0;
      mosi_nxt      = tx_buffer_nxt[BYTE_W-1];
    end
  end

  // state update, one step per accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_buffer_r <= '0;
      tx_full_r   <= 1'b0;
      shift_reg_r <= '0;
      bit_count_r <= '0;
      div_count_r <= '0;
      rx_buffer_r <= '0;
      rx_full_r   <= 1'b0;
      shifting_r  <= 1'b0;
      phase_r     <= 1'b0;
      mosi_r      <= 1'b0;
      latch_r     <= 1'b0;
    end else if (step_i) begin
      tx_buffer_r <= tx_buffer_nxt;
      tx_full_r   <= tx_full_nxt;
      shift_reg_r <= shift_reg_nxt;
      bit_count_r <= bit_count_nxt;
      div_count_r <= div_count_nxt;
      rx_buffer_r <= rx_buffer_nxt;
      rx_full_r   <= rx_full_nxt;
      shifting_r  <= shifting_nxt;
      phase_r     <= phase_nxt;
      mosi_r      <= mosi_nxt;
      latch_r     <= latch_nxt;
    end
  end

  // result of this tick
  always_comb begin
    result_o.sclk_out     = cfg_i.clock_polarity ^ phase_nxt;
    result_o.mosi_out     = mosi_nxt;
    result_o.read_data    = rdata;
    result_o.tx_empty     = ~tx_full_nxt;
    result_o.rx_not_empty = rx_full_nxt;
    result_o.busy_res     = shifting_nxt;
  end

endmodule

/* sim/tb_spi_master_port_unit.sv */
// testbench for spi_master_port_unit: random and directed ticks checked against a local model
`timescale 1ns / 1ps

module tb_spi_master_port_unit;
  import spimp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_t                    in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_t                   out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  spi_master_port_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // spi port model state
  cfg_t              port_cfg;
  logic [BYTE_W-1:0] tx_hold, shift_q, rx_hold;
  logic              tx_loaded, rx_loaded, busy_q;
  logic              sck_half, mosi_q, early_bit;
  logic [BITCNT_W-1:0] bit_cnt;
  logic [DIV_W-1:0]  div_cnt;

  out_t        port_state_q[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;

  // advance the port model by one tick and return the line and status levels
  task automatic spi_port_step(input in_t t, output out_t r);
    logic [LIMIT_W-1:0] half_limit;
    logic [BYTE_W-1:0]  rd;
    logic               lead_edge;
    half_limit = LIMIT_W'(1) << port_cfg.prescaler_code;
    rd = '0;

    // bus access, status taken before the engine moves
    case (action_t'(t.action))
      ACT_WRITE: begin
        if (!tx_loaded) begin
          tx_hold = t.write_data;
          tx_loaded = 1'b1;
        end
      end
      ACT_READ_DATA: begin
        rd = rx_hold;
        rx_loaded = 1'b0;
      end
      ACT_READ_STATUS: begin
        rd[STAT_RXNE_BIT] = rx_loaded;
        rd[STAT_TXE_BIT]  = !tx_loaded;
        rd[STAT_BSY_BIT]  = busy_q;
      end
      default: ;
    endcase

    // shift engine: an sck edge when the divider reaches its limit or wraps
    if (busy_q) begin
      div_cnt = div_cnt + DIV_W'(1);
      if (div_cnt == '0 || {1'b0, div_cnt} >= half_limit) begin
        div_cnt = '0;
        lead_edge = !sck_half;
        sck_half = !sck_half;
        if (lead_edge) begin
          if (port_cfg.clock_phase) begin
            mosi_q = shift_q[BYTE_W-1];
            shift_q = shift_q << 1;
          end else begin
            early_bit = t.miso_in;
          end
        end else begin
          if (port_cfg.clock_phase)
            shift_q = shift_q | BYTE_W'(t.miso_in);
          else
            shift_q = {shift_q[BYTE_W-2:0], early_bit};
          bit_cnt = bit_cnt + BITCNT_W'(1);
          if (bit_cnt >= BITS_PER_BYTE) begin
            busy_q = 1'b0;
            bit_cnt = '0;
            // overrun drops the new byte
            if (!rx_loaded) begin
              rx_hold = shift_q;
              rx_loaded = 1'b1;
            end
          end else if (!port_cfg.clock_phase) begin
            mosi_q = shift_q[BYTE_W-1];
          end
        end
      end
    end

    // start a buffered byte
    if (!busy_q && tx_loaded && port_cfg.enable) begin
      shift_q = tx_hold;
      tx_loaded = 1'b0;
      busy_q = 1'b1;
      bit_cnt = '0;
      div_cnt = '0;
      sck_half = 1'b0;
      mosi_q = shift_q[BYTE_W-1];
    end

    r.sclk_out     = port_cfg.clock_polarity ^ sck_half;
    r.mosi_out     = mosi_q;
    r.read_data    = rd;
    r.tx_empty     = !tx_loaded;
    r.rx_not_empty = rx_loaded;
    r.busy_res     = busy_q;
  endtask

  // one tick transaction, sent in bursts with random gaps
  task automatic send_tick(input in_t t);
    out_t r;
    int   gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    spi_port_step(t, r);
    port_state_q.push_back(r);
  endtask

  // stop sending and wait for every expected result
  task automatic settle();
    in_valid <= 1'b0;
    while (port_state_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // register write, only while no tick is in flight
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ENABLE:    port_cfg.enable         = val[0];
      CFG_PRESCALER: port_cfg.prescaler_code = val[PRESC_W-1:0];
      CFG_CPOL:      port_cfg.clock_polarity = val[0];
      CFG_CPHA:      port_cfg.clock_phase    = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // random tick, biased to writes into an empty buffer and, if eager_reads, reads of a full one
  function automatic in_t random_tick(input bit eager_reads);
    in_t         t;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    t.write_data = BYTE_W'($urandom);
    t.miso_in = 1'($urandom);
    if (!tx_loaded && pick < 30)
      t.action = ACT_WRITE;
    else if (rx_loaded && eager_reads && pick < 60)
      t.action = ACT_READ_DATA;
    else if (pick < 66)
      t.action = ACT_WRITE;
    else if (pick < 71)
      t.action = ACT_READ_DATA;
    else if (pick < 80)
      t.action = ACT_READ_STATUS;
    else
      t.action = ACT_NONE;
    return t;
  endfunction

  task automatic run_traffic(input int n, input bit eager_reads);
    repeat (n) send_tick(random_tick(eager_reads));
  endtask

  task automatic quiet_ticks(input int n);
    repeat (n) send_tick('{action: ACT_NONE, write_data: 8'h00, miso_in: 1'($urandom)});
  endtask

  // status and data reads from reset, writes while disabled and while full, first byte
  task automatic test_after_reset();
    send_tick('{action: ACT_READ_STATUS, write_data: 8'h00, miso_in: 1'b0});
    send_tick('{action: ACT_READ_DATA, write_data: 8'h00, miso_in: 1'b1});
    send_tick('{action: ACT_WRITE, write_data: 8'h00, miso_in: 1'b0});
    send_tick('{action: ACT_WRITE, write_data: 8'hFF, miso_in: 1'b1});
    send_tick('{action: ACT_READ_STATUS, write_data: 8'hFF, miso_in: 1'b0});
    settle();
    write_reg(CFG_ENABLE, 3'd1);
    repeat (18) send_tick('{action: ACT_NONE, write_data: 8'h00, miso_in: 1'b1});
    send_tick('{action: ACT_READ_DATA, write_data: 8'h00, miso_in: 1'b0});
    send_tick('{action: ACT_READ_STATUS, write_data: 8'h00, miso_in: 1'b0});
  endtask

  // all four cpol/cpha modes, fast and slower sck, with and without overruns
  task automatic test_clock_modes();
    for (int m = 0; m < 4; m++) begin
      settle();
      write_reg(CFG_CPOL, 3'(m[1]));
      write_reg(CFG_CPHA, 3'(m[0]));
      write_reg(CFG_PRESCALER, 3'd0);
      run_traffic(40, 1'b1);
      settle();
      write_reg(CFG_PRESCALER, 3'd1);
      run_traffic(40, 1'b0);
    end
  endtask

  // enable cleared mid-byte: the byte ends, the buffered one waits
  task automatic test_enable_drop();
    settle();
    write_reg(CFG_PRESCALER, 3'd1);
    write_reg(CFG_ENABLE, 3'd1);
    send_tick('{action: ACT_READ_DATA, write_data: 8'h00, miso_in: 1'b0});
    send_tick('{action: ACT_WRITE, write_data: 8'hC3, miso_in: 1'b1});
    quiet_ticks(6);
    settle();
    write_reg(CFG_ENABLE, 3'd0);
    send_tick('{action: ACT_WRITE, write_data: 8'($urandom), miso_in: 1'b0});
    quiet_ticks(40);
    send_tick('{action: ACT_READ_STATUS, write_data: 8'h00, miso_in: 1'b0});
    settle();
    write_reg(CFG_ENABLE, 3'd1);
    quiet_ticks(40);
    send_tick('{action: ACT_READ_DATA, write_data: 8'h00, miso_in: 1'b0});
  endtask

  // slowest sck, then prescaler dropped mid-byte below the running divider
  task automatic test_prescaler_extremes();
    settle();
    write_reg(CFG_CPOL, 3'd1);
    write_reg(CFG_CPHA, 3'd1);
    write_reg(CFG_PRESCALER, 3'd7);
    send_tick('{action: ACT_READ_DATA, write_data: 8'h00, miso_in: 1'b0});
    send_tick('{action: ACT_WRITE, write_data: 8'($urandom), miso_in: 1'b1});
    quiet_ticks(260);
    settle();
    write_reg(CFG_PRESCALER, 3'd0);
    quiet_ticks(40);
    send_tick('{action: ACT_READ_DATA, write_data: 8'h00, miso_in: 1'b0});
  endtask

  // random register settings, including changes while a byte is on the bus
  task automatic test_random_settings();
    repeat (4) begin
      settle();
      write_reg(CFG_ENABLE, 3'($urandom_range(0, 4) != 0));
      write_reg(CFG_PRESCALER, 3'($urandom_range(0, 3)));
      write_reg(CFG_CPOL, 3'($urandom_range(0, 1)));
      write_reg(CFG_CPHA, 3'($urandom_range(0, 1)));
      run_traffic(40, 1'($urandom));
    end
  endtask

  // receiver stall pattern: modes of random length
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(10, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
      STALL_PERIODIC: out_stall <= (stall_left[2:0] < 3'd3);
      default:        out_stall <= 1'b0;
    endcase
  end

  function automatic void note_failure(input string msg);
    if (fail_count < MAX_REPORTS)
      $display("cycle %0d: %s", cycle_count, msg);
    fail_count++;
  endfunction

  // result check against the oldest expected transaction
  always @(posedge clk) begin
    out_t  want;
    string diff;
    if (rst_n && out_valid && !out_stall) begin
      if (port_state_q.size() == 0) begin
        note_failure($sformatf("unexpected result %p", out_data));
      end else begin
        want = port_state_q.pop_front();
        diff = "";
        if (out_data.sclk_out !== want.sclk_out)         diff = {diff, " sclk_out"};
        if (out_data.mosi_out !== want.mosi_out)         diff = {diff, " mosi_out"};
        if (out_data.read_data !== want.read_data)       diff = {diff, " read_data"};
        if (out_data.tx_empty !== want.tx_empty)         diff = {diff, " tx_empty"};
        if (out_data.rx_not_empty !== want.rx_not_empty) diff = {diff, " rx_not_empty"};
        if (out_data.busy_res !== want.busy_res)         diff = {diff, " busy_res"};
        if (diff != "")
          note_failure($sformatf("mismatch in%s: expected %p, got %p", diff, want, out_data));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    port_cfg  = '0;
    tx_hold   = '0;
    shift_q   = '0;
    rx_hold   = '0;
    tx_loaded = 1'b0;
    rx_loaded = 1'b0;
    busy_q    = 1'b0;
    sck_half  = 1'b0;
    mosi_q    = 1'b0;
    early_bit = 1'b0;
    bit_cnt   = '0;
    div_cnt   = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_after_reset();
    test_clock_modes();
    test_enable_drop();
    test_prescaler_extremes();
    test_random_settings();

    settle();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && port_state_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

/* files.f */
src/spimp_pkg.sv
src/spimp_core.sv
src/spi_master_port_unit.sv
sim/tb_spi_master_port_unit.sv
